/* hdl/u8d_pkg.sv */
package u8d_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned CountW = 3;

  localparam logic [ByteW-1:0] ContMask  = 8'b11000000;
  localparam logic [ByteW-1:0] ContTag   = 8'b10000000;
  localparam logic [ByteW-1:0] ContBits  = 8'b00111111;
  localparam logic [ByteW-1:0] Lead2Mask = 8'b11100000;
  localparam logic [ByteW-1:0] Lead2Bits = 8'b00011111;
  localparam logic [ByteW-1:0] Lead3Mask = 8'b11110000;
  localparam logic [ByteW-1:0] Lead3Bits = 8'b00001111;
  localparam logic [ByteW-1:0] Lead4Mask = 8'b11111000;
  localparam logic [ByteW-1:0] Lead4Bits = 8'b00000111;
  localparam logic [ByteW-1:0] Lead1Bits = 8'b01111111;

  localparam logic [CountW-1:0] MaxSeqLen = 3'd4;
  localparam logic [CountW-1:0] CountMax  = 3'd7;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             end_of_seq;
  } in_beat_t;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           invalid;
  } out_beat_t;

  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } res_t;

  typedef struct packed {
    logic            bad;
    logic [CountW-1:0] len;
    logic [CpW-1:0]  bits;
  } lead_t;

  function automatic lead_t decode_lead(input logic [ByteW-1:0] b);
    lead_t l;
    l = '0;
    case (b) inside
      8'b0???????: begin
        l.len  = 3'd1;
        l.bits = CpW'(b & Lead1Bits);
      end
      8'b110?????: begin
        l.len  = 3'd2;
        l.bits = CpW'(b & Lead2Bits);
      end
      8'b1110????: begin
        l.len  = 3'd3;
        l.bits = CpW'(b & Lead3Bits);
      end
      8'b11110???: begin
        l.len  = 3'd4;
        l.bits = CpW'(b & Lead4Bits);
      end
      default: begin
        l.bad = 1'b1;
      end
    endcase
    return l;
  endfunction

endpackage

/* hdl/u8d_in_if.sv */
interface u8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_seq;

  modport source (output valid, output in_byte, output end_of_seq, input ready);
  modport sink   (input valid, input in_byte, input end_of_seq, output ready);
endinterface

/* hdl/u8d_out_if.sv */
interface u8d_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        invalid;

  modport source (output valid, output code_point, output invalid, input ready);
  modport sink   (input valid, input code_point, input invalid, output ready);
endinterface

/* hdl/u8d_in_reg.sv */
module u8d_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  u8d_in_if.sink            in_i,
  input  logic              take_i,
  output logic              valid_o,
  output u8d_pkg::in_beat_t beat_o
);
  import u8d_pkg::*;

  logic     valid_q;
  in_beat_t beat_q;

  assign in_i.ready = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      beat_q.in_byte    <= in_i.in_byte;
      beat_q.end_of_seq <= in_i.end_of_seq;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;
endmodule

/* hdl/u8d_core.sv */
module u8d_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  u8d_pkg::in_beat_t beat_i,
  input  logic              res_ready_i,
  output logic              take_o,
  output u8d_pkg::res_t     res_o
);
  import u8d_pkg::*;

  logic [CpW-1:0]    accum_q, accum_d, accum_n;
  logic [CountW-1:0] seen_q, seen_d, seen_n;
  logic [CountW-1:0] want_q, want_d, want_n;
  logic              bad_q, bad_d, bad_n;
  logic              fail;
  lead_t             lead;
  logic [ByteW-1:0]  b;

  assign b      = beat_i.in_byte;
  assign lead   = decode_lead(b);
  assign take_o = valid_i && (!beat_i.end_of_seq || res_ready_i);

  always_comb begin
    accum_n = accum_q;
    want_n  = want_q;
    bad_n   = bad_q;
    if (seen_q == '0) begin
      want_n  = lead.len;
      accum_n = lead.bits;
      bad_n   = lead.bad;
    end else begin
      if ((b & ContMask) != ContTag) begin
        bad_n = 1'b1;
      end
      if (seen_q < MaxSeqLen) begin
        accum_n = {accum_q[CpW-7:0], b[5:0] & ContBits[5:0]};
      end else begin
        bad_n = 1'b1;
      end
    end
    seen_n = (seen_q < CountMax) ? seen_q + 3'd1 : seen_q;
    fail   = bad_n || (want_n == '0) || (seen_n != want_n) || (seen_n > MaxSeqLen);
  end

  always_comb begin
    accum_d = accum_q;
    seen_d  = seen_q;
    want_d  = want_q;
    bad_d   = bad_q;
    if (take_o) begin
      if (beat_i.end_of_seq) begin
        accum_d = '0;
        seen_d  = '0;
        want_d  = '0;
        bad_d   = 1'b0;
      end else begin
        accum_d = accum_n;
        seen_d  = seen_n;
        want_d  = want_n;
        bad_d   = bad_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q <= '0;
      seen_q  <= '0;
      want_q  <= '0;
      bad_q   <= 1'b0;
    end else begin
      accum_q <= accum_d;
      seen_q  <= seen_d;
      want_q  <= want_d;
      bad_q   <= bad_d;
    end
  end

  assign res_o.valid           = take_o && beat_i.end_of_seq;
  assign res_o.beat.code_point = fail ? '0 : accum_n;
  assign res_o.beat.invalid    = fail;
endmodule

/* hdl/u8d_out_reg.sv */
module u8d_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  u8d_pkg::res_t res_i,
  output logic          ready_o,
  u8d_out_if.source     out_o
);
  import u8d_pkg::*;

  logic      valid_q;
  out_beat_t beat_q;

  assign ready_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && res_i.valid) begin
      beat_q <= res_i.beat;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.code_point = beat_q.code_point;
  assign out_o.invalid    = beat_q.invalid;
endmodule

/* hdl/utf8_sequence_decoder_top.sv */
// Path: each byte is held in the input register; a final byte's result is decoded
// combinationally and registered in the output register, which drives the output.
// Throughput: one byte per cycle while the output register can accept a result, set by
// the single decode step between the input register and the result register.
// Reset: asynchronous, active low; clears both stage valids and the sequence state.
module utf8_sequence_decoder_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  u8d_in_if.sink    in_i,
  u8d_out_if.source out_o
);
  import u8d_pkg::*;

  logic     in_valid;
  in_beat_t in_beat;
  logic     take;
  logic     res_ready;
  res_t     res;

  u8d_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .valid_o (in_valid),
    .beat_o  (in_beat)
  );

  u8d_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid),
    .beat_i      (in_beat),
    .res_ready_i (res_ready),
    .take_o      (take),
    .res_o       (res)
  );

  u8d_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .res_i   (res),
    .ready_o (res_ready),
    .out_o   (out_o)
  );
endmodule

/* bench/utf8_point_checker.sv */
`timescale 1ns / 100ps

module utf8_point_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  u8d_in_if           byte_i,
  u8d_out_if          point_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned points_due_o
);
  import u8d_pkg::*;

  logic [CpW-1:0]    acc_q;
  logic [CountW-1:0] seen_q;
  logic [CountW-1:0] want_q;
  logic              bad_q;
  out_beat_t         points_q[$];
  int unsigned       errs;

  initial begin
    errs           = 0;
    mismatch_cnt_o = 0;
    points_due_o   = 0;
  end

  task automatic clear_seq();
    acc_q  = '0;
    seen_q = '0;
    want_q = '0;
    bad_q  = 1'b0;
  endtask

  task automatic fold_byte(input logic [ByteW-1:0] b, input logic last);
    out_beat_t pt;
    logic      wrong;
    if (seen_q == '0) begin
      case (b) inside
        8'b0???????: begin
          want_q = 3'd1;
          acc_q  = CpW'(b[6:0]);
        end
        8'b110?????: begin
          want_q = 3'd2;
          acc_q  = CpW'(b[4:0]);
        end
        8'b1110????: begin
          want_q = 3'd3;
          acc_q  = CpW'(b[3:0]);
        end
        8'b11110???: begin
          want_q = 3'd4;
          acc_q  = CpW'(b[2:0]);
        end
        default: begin
          want_q = '0;
          acc_q  = '0;
          bad_q  = 1'b1;
        end
      endcase
    end else begin
      if ((b & ContMask) != ContTag) bad_q = 1'b1;
      if (seen_q < MaxSeqLen) begin
        acc_q = {acc_q[CpW-7:0], b[5:0]};
      end else begin
        bad_q = 1'b1;
      end
    end
    if (seen_q != CountMax) seen_q = seen_q + 3'd1;
    if (last) begin
      wrong = bad_q || (want_q == '0) || (seen_q != want_q) || (seen_q > MaxSeqLen);
      pt.invalid    = wrong;
      pt.code_point = wrong ? '0 : acc_q;
      points_q.push_back(pt);
      clear_seq();
    end
  endtask

  task automatic match_point();
    out_beat_t want;
    if (points_q.size() == 0) begin
      $display("%0t: unexpected result: expected none, got cp=%h invalid=%b",
               $time, point_i.code_point, point_i.invalid);
      errs++;
    end else begin
      want = points_q.pop_front();
      if (point_i.code_point !== want.code_point) begin
        $display("%0t: code_point: expected %h, got %h",
                 $time, want.code_point, point_i.code_point);
        errs++;
      end
      if (point_i.invalid !== want.invalid) begin
        $display("%0t: invalid: expected %b, got %b", $time, want.invalid, point_i.invalid);
        errs++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_seq();
      points_q.delete();
      points_due_o <= 0;
    end else begin
      if (point_i.valid && point_i.ready) match_point();
      if (byte_i.valid && byte_i.ready) fold_byte(byte_i.in_byte, byte_i.end_of_seq);
      points_due_o   <= points_q.size();
      mismatch_cnt_o <= errs;
    end
  end

endmodule

/* bench/tb_utf8_sequence_decoder_top.sv */
`timescale 1ns / 100ps

module tb_utf8_sequence_decoder_top;

  localparam int HoldOffCycles = 200;
  localparam int StallLimit    = 1000;
  localparam int TotalBeats    = 450;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  u8d_in_if  byte_if ();
  u8d_out_if point_if ();

  int unsigned mismatches;
  int unsigned points_due;
  int unsigned beats_sent;
  int          in_gap_max;
  int          rx_gap_max;
  bit          rx_hold_req;

  utf8_sequence_decoder_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_if),
    .out_o  (point_if)
  );

  utf8_point_checker u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .byte_i         (byte_if),
    .point_i        (point_if),
    .mismatch_cnt_o (mismatches),
    .points_due_o   (points_due)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_if.valid      <= 1'b1;
    byte_if.in_byte    <= b;
    byte_if.end_of_seq <= last;
    do @(posedge clk_i); while (!byte_if.ready);
    beats_sent++;
  endtask

  task automatic send_word(input logic [31:0] w, input int n);
    int i;
    for (i = n - 1; i >= 0; i--) send_byte(w[8*i +: 8], i == 0);
  endtask

  // drop valid and hold until every predicted code point has come back
  task automatic wait_drained();
    byte_if.valid <= 1'b0;
    @(posedge clk_i);
    while (points_due != 0) @(posedge clk_i);
  endtask

  task automatic send_random_seq();
    logic [7:0] seq [0:8];
    int         kind;
    int         len;
    int         n;
    int         i;
    kind = $urandom_range(0, 9);
    len  = $urandom_range(1, 4);
    case (len)
      1:       seq[0] = {1'b0, 7'($urandom)};
      2:       seq[0] = {3'b110, 5'($urandom)};
      3:       seq[0] = {4'b1110, 4'($urandom)};
      default: seq[0] = {5'b11110, 3'($urandom)};
    endcase
    for (i = 1; i < 9; i++) seq[i] = {2'b10, 6'($urandom)};
    n = len;
    if (kind == 7) begin
      // corrupt one byte of an otherwise well-formed sequence
      seq[$urandom_range(0, len - 1)] = 8'($urandom);
    end else if (kind == 8) begin
      n = $urandom_range(1, 9);
    end else if (kind == 9) begin
      n = $urandom_range(1, 9);
      for (i = 0; i < 9; i++) seq[i] = 8'($urandom);
    end
    for (i = 0; i < n; i++) send_byte(seq[i], i == n - 1);
  endtask

  initial begin
    byte_if.valid      <= 1'b0;
    byte_if.in_byte    <= '0;
    byte_if.end_of_seq <= 1'b0;
    beats_sent  = 0;
    in_gap_max  = 8;
    rx_gap_max  = 8;
    rx_hold_req = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(32'h0000_0000, 1);
    send_word(32'h0000_007F, 1);
    send_word(32'h0000_DFBF, 2);
    send_word(32'h00EF_BFBF, 3);
    send_word(32'hF7BF_BFBF, 4);
    send_word(32'h0000_0080, 1);
    send_word(32'h0000_00FF, 1);
    send_word(32'h0000_C1BF, 2);
    send_word(32'h00ED_A080, 3);
    send_word(32'h0000_C328, 2);
    send_word(32'h0000_E282, 2);
    send_byte(8'hF0, 1'b0);
    send_word(32'h9080_8080, 4);
    wait_drained();

    while (beats_sent < 200) send_random_seq();

    // fill the block behind a stalled sink with back-to-back beats
    in_gap_max  = 0;
    rx_gap_max  = 0;
    rx_hold_req = 1'b1;
    while (beats_sent < 260) send_random_seq();
    wait_drained();
    in_gap_max = 8;
    rx_gap_max = 8;

    while (beats_sent < TotalBeats) send_random_seq();
    wait_drained();
    repeat (4) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : sink_side
    int stall;
    point_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        stall       = HoldOffCycles;
        rx_hold_req = 1'b0;
      end else begin
        stall = $urandom_range(0, rx_gap_max);
      end
      if (stall > 0) begin
        point_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      point_if.ready <= 1'b1;
      do @(posedge clk_i); while (!point_if.valid);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((byte_if.valid && byte_if.ready) || (point_if.valid && point_if.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
      if (idle >= StallLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

endmodule
